// ===== sv/wsms_pkg.sv =====
// Shared types and constants for the multichannel LED bit serializer.
package wsms_pkg;

    localparam int BYTE_W   = 8;
    localparam int IN_BYTES = 4;
    localparam int BYTES_W  = BYTE_W * IN_BYTES;
    localparam int PIN_W    = 4;
    localparam int BIT_W    = 3;
    localparam int TRAIL_W  = 11;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [BIT_W-1:0]  LAST_BIT = 3'd7;

    localparam logic [BYTE_W-1:0] SLOT_PERIOD_RST = 8'd29;
    localparam logic [BYTE_W-1:0] ONE_HIGH_RST    = 8'd17;
    localparam logic [BYTE_W-1:0] ZERO_HIGH_RST   = 8'd9;
    localparam logic [BYTE_W-1:0] TRAILER_RST     = 8'd32;

    localparam logic [1:0] REG_SLOT_PERIOD = 2'd0;
    localparam logic [1:0] REG_ONE_HIGH    = 2'd1;
    localparam logic [1:0] REG_ZERO_HIGH   = 2'd2;
    localparam logic [1:0] REG_TRAILER     = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_DATA    = 4'b0010,
        PH_TRAILER = 4'b0100,
        PH_STARVED = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] slot_period;
        logic [BYTE_W-1:0] one_high_ticks;
        logic [BYTE_W-1:0] zero_high_ticks;
        logic [BYTE_W-1:0] trailer_bytes;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic [BYTES_W-1:0] channel_bytes;
        logic               last_byte;
    } in_item_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             ready_res;
        logic             busy_res;
        logic             underrun;
        logic             frame_done;
    } out_item_t;

    // What the sequencer hands to every lane for the current tick.
    typedef struct packed {
        logic               data_active;
        logic [BIT_W-1:0]   bit_index;
        logic [BYTE_W-1:0]  tick_count;
        logic [BYTES_W-1:0] shift_bytes;
    } lane_ctrl_t;

    // Per-tick status from the sequencer.
    typedef struct packed {
        logic ready_res;
        logic busy_res;
        logic underrun;
        logic frame_done;
    } seq_status_t;

endpackage

// ===== sv/wsms_ifs.sv =====
// Valid/ready stream interfaces for tick requests and per-tick results.
interface wsms_in_if;
    import wsms_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wsms_out_if;
    import wsms_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ws2812_multichannel_serializer_core.sv =====
// Top level: config port, sequencer, per-channel lanes, pin merge and result skid buffer.
// Each accepted tick's result is registered: in the output register, or in the skid if results stalls.
// Throughput: one tick request per cycle while the skid is empty; the sequencer updates all state
// on each accepted request, and the lanes compare in parallel, one comparator per lane.
// A two-entry output buffer (output register plus skid) keeps ticks flowing one stall deep.
// Reset (rst_n low, async): idle phase, empty holding buffer, registers at default timing.
module ws2812_multichannel_serializer_core #(
    parameter int CHANNELS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wsms_in_if.sink                       ticks,
    wsms_out_if.source                    results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsms_pkg::PADDR_W-1:0]  paddr,
    input  logic [wsms_pkg::PDATA_W-1:0]  pwdata,
    output logic [wsms_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import wsms_pkg::*;

    // Only channels carried by the input word and the pin vector get a lane.
    localparam int LANES = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

    cfg_t         cfg;
    lane_ctrl_t   ctl;
    seq_status_t  status;
    logic [PIN_W-1:0] pins;
    logic         step;
    out_item_t    res;

    out_item_t    out_data_reg;
    logic         out_valid_reg;
    out_item_t    skid_data_reg;
    logic         skid_valid_reg;
    logic         out_free;

    wsms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign ticks.ready = !skid_valid_reg;
    assign step        = ticks.valid && ticks.ready;

    wsms_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (ticks.data),
        .cfg    (cfg),
        .ctl    (ctl),
        .status (status)
    );

    for (genvar g = 0; g < PIN_W; g++)
    begin : g_lane
        if (g < LANES)
        begin : g_on
            wsms_lane u_lane (
                .lane_byte (ctl.shift_bytes[g*BYTE_W +: BYTE_W]),
                .ctl       (ctl),
                .cfg       (cfg),
                .pin       (pins[g])
            );
        end
        else
        begin : g_off
            assign pins[g] = 1'b0;
        end
    end

    always_comb
    begin
        res.pin_levels = pins;
        res.ready_res  = status.ready_res;
        res.busy_res   = status.busy_res;
        res.underrun   = status.underrun;
        res.frame_done = status.frame_done;
    end

    assign out_free      = !out_valid_reg || results.ready;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= step;
            end
        end
        else if (step)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (step)
            begin
                out_data_reg <= res;
            end
        end
        else if (step)
        begin
            skid_data_reg <= res;
        end
    end

endmodule

// ===== sv/wsms_cfg.sv =====
// APB register file for slot timing and trailer length.
module wsms_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsms_pkg::PADDR_W-1:0]  paddr,
    input  logic [wsms_pkg::PDATA_W-1:0]  pwdata,
    output logic [wsms_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output wsms_pkg::cfg_t                cfg
);
    import wsms_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_SLOT_PERIOD: cfg_next.slot_period     = pwdata[BYTE_W-1:0];
                REG_ONE_HIGH:    cfg_next.one_high_ticks  = pwdata[BYTE_W-1:0];
                REG_ZERO_HIGH:   cfg_next.zero_high_ticks = pwdata[BYTE_W-1:0];
                REG_TRAILER:     cfg_next.trailer_bytes   = pwdata[BYTE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_SLOT_PERIOD: prdata[BYTE_W-1:0] = cfg_reg.slot_period;
            REG_ONE_HIGH:    prdata[BYTE_W-1:0] = cfg_reg.one_high_ticks;
            REG_ZERO_HIGH:   prdata[BYTE_W-1:0] = cfg_reg.zero_high_ticks;
            REG_TRAILER:     prdata[BYTE_W-1:0] = cfg_reg.trailer_bytes;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_period     <= SLOT_PERIOD_RST;
            cfg_reg.one_high_ticks  <= ONE_HIGH_RST;
            cfg_reg.zero_high_ticks <= ZERO_HIGH_RST;
            cfg_reg.trailer_bytes   <= TRAILER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/wsms_lane.sv =====
// One channel: picks the current bit and compares the tick count to its high time.
module wsms_lane (
    input  logic [wsms_pkg::BYTE_W-1:0] lane_byte,
    input  wsms_pkg::lane_ctrl_t        ctl,
    input  wsms_pkg::cfg_t              cfg,
    output logic                        pin
);
    import wsms_pkg::*;

    logic              bit_val;
    logic [BYTE_W-1:0] limit;

    // MSB first: bit index 0 selects bit 7
    assign bit_val = lane_byte[LAST_BIT - ctl.bit_index];
    assign limit   = bit_val ? cfg.one_high_ticks : cfg.zero_high_ticks;
    assign pin     = ctl.data_active && (ctl.tick_count < limit);

endmodule

// ===== sv/wsms_seq.sv =====
// Slot/bit/byte sequencer with holding buffer, starve handling and trailer count.
module wsms_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  wsms_pkg::in_item_t      item,
    input  wsms_pkg::cfg_t          cfg,
    output wsms_pkg::lane_ctrl_t    ctl,
    output wsms_pkg::seq_status_t   status
);
    import wsms_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   tick_reg, tick_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [BYTES_W-1:0]  shift_reg, shift_next;
    logic [BYTES_W-1:0]  held_bytes_reg;
    logic                held_valid_reg, held_valid_next;
    logic                held_last_reg, held_last_next;
    logic                cur_last_reg, cur_last_next;
    logic [TRAIL_W-1:0]  trail_reg, trail_next;

    logic                load_ok;
    logic                hv;
    logic [BYTES_W-1:0]  hb;
    logic                hl;
    logic                slot_end;
    logic [TRAIL_W-1:0]  trail_dec;
    logic                under;
    logic                done;

    assign load_ok = item.load && !held_valid_reg;
    assign hv      = held_valid_reg || load_ok;
    assign hb      = load_ok ? item.channel_bytes : held_bytes_reg;
    assign hl      = load_ok ? item.last_byte : held_last_reg;
    assign slot_end  = (tick_reg >= cfg.slot_period);
    assign trail_dec = (trail_reg != '0) ? trail_reg - 1'b1 : trail_reg;

    assign ctl.data_active = (phase_reg == PH_DATA);
    assign ctl.bit_index   = bit_reg;
    assign ctl.tick_count  = tick_reg;
    assign ctl.shift_bytes = shift_reg;

    assign status.ready_res  = !held_valid_reg;
    assign status.busy_res   = (phase_reg != PH_IDLE);
    assign status.underrun   = under;
    assign status.frame_done = done;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        held_valid_next = hv;
        held_last_next  = hl;
        cur_last_next   = cur_last_reg;
        trail_next      = trail_reg;
        under           = 1'b0;
        done            = 1'b0;

        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (hv)
                begin
                    shift_next      = hb;
                    cur_last_next   = hl;
                    held_valid_next = 1'b0;
                    phase_next      = PH_DATA;
                    bit_next        = '0;
                    tick_next       = '0;
                end
            end
            PH_DATA, PH_TRAILER, PH_STARVED:
            begin
                if (!slot_end)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                else
                begin
                    tick_next = '0;
                    if (phase_reg == PH_TRAILER)
                    begin
                        trail_next = trail_dec;
                        if (trail_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    else if (bit_reg == LAST_BIT)
                    begin
                        // byte boundary
                        if (phase_reg == PH_DATA && cur_last_reg)
                        begin
                            trail_next    = {cfg.trailer_bytes, 3'b000};
                            cur_last_next = 1'b0;
                            if (cfg.trailer_bytes == '0)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TRAILER;
                            end
                        end
                        else if (hv)
                        begin
                            shift_next      = hb;
                            cur_last_next   = hl;
                            held_valid_next = 1'b0;
                            phase_next      = PH_DATA;
                            bit_next        = '0;
                        end
                        else
                        begin
                            phase_next = PH_STARVED;
                            bit_next   = '0;
                            under      = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_next = bit_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            cur_last_reg   <= 1'b0;
            trail_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            cur_last_reg   <= cur_last_next;
            trail_reg      <= trail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && load_ok)
        begin
            held_bytes_reg <= item.channel_bytes;
        end
    end

endmodule

// ===== sv/wsms_checker.sv =====
// Port-level checks for the serializer core, bound to the top level.
module wsms_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input wsms_pkg::out_item_t           out_data
);
    import wsms_pkg::*;

    // a full skid means the output register is holding a stalled result
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled while no result is pending");

    a_done_not_under: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.underrun && out_data.frame_done))
        else $error("underrun and frame_done in the same result");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.frame_done) |-> out_data.busy_res)
        else $error("frame_done while not busy");

    a_pins_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.pin_levels != '0)) |-> out_data.busy_res)
        else $error("pin driven high while idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind ws2812_multichannel_serializer_core wsms_checker u_wsms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (ticks.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);
